### design/assert_macros.svh
// Assertion helpers used by the checker file.
// Clock and reset are taken from the names clk and rst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    `ASSERT_PROP(label, 1'b1 |-> (expr), msg)

`endif

### design/yuvrgb_pkg.sv
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared widths, register indexes and constants of the YUV 4:2:0 to RGB unit.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SLOT_W    = 2;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Register indexes on the configuration channel
    localparam cfg_idx_t CFG_BLUE_FIRST    = 2'd0;
    localparam cfg_idx_t CFG_FOUR_CHANNELS = 2'd1;
    localparam cfg_idx_t CFG_ALPHA_FILL    = 2'd2;

    // Pixel slots inside a 2x2 group
    localparam slot_t SLOT_TOP_LEFT     = 2'd0;
    localparam slot_t SLOT_TOP_RIGHT    = 2'd1;
    localparam slot_t SLOT_BOTTOM_LEFT  = 2'd2;
    localparam slot_t SLOT_BOTTOM_RIGHT = 2'd3;

    localparam byte_t ALPHA_RESET = 8'd255;
    localparam byte_t LUMA_BLACK  = 8'd16;

    // BT.601 coefficients, luma in Q7, chroma in Q6
    localparam logic [16:0]        Y_GAIN  = 17'd149;
    localparam logic signed [15:0] RV_GAIN = 16'sd102;
    localparam logic signed [15:0] GU_GAIN = 16'sd25;
    localparam logic signed [15:0] GV_GAIN = 16'sd52;
    localparam logic signed [15:0] BU_GAIN = 16'sd129;

endpackage

### design/yuvrgb_group_if.sv
// ----------------------------------------------------------------------------
// yuvrgb_group_if
// Channel of 2x2 luma groups with their shared chroma pair.
// ----------------------------------------------------------------------------
interface yuvrgb_group_if
    import yuvrgb_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t luma_top_left;
    byte_t luma_top_right;
    byte_t luma_bottom_left;
    byte_t luma_bottom_right;
    byte_t chroma_u;
    byte_t chroma_v;

    modport source
    (
        output valid, luma_top_left, luma_top_right, luma_bottom_left,
               luma_bottom_right, chroma_u, chroma_v,
        input  ready
    );

    modport sink
    (
        input  valid, luma_top_left, luma_top_right, luma_bottom_left,
               luma_bottom_right, chroma_u, chroma_v,
        output ready
    );
endinterface

### design/yuvrgb_pixel_if.sv
// ----------------------------------------------------------------------------
// yuvrgb_pixel_if
// Channel of converted pixels, one pixel per word.
// ----------------------------------------------------------------------------
interface yuvrgb_pixel_if
    import yuvrgb_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t first_byte;
    byte_t second_byte;
    byte_t third_byte;
    byte_t fourth_byte;
    slot_t pixel_slot;
    logic  last_pixel;

    modport source
    (
        output valid, first_byte, second_byte, third_byte, fourth_byte,
               pixel_slot, last_pixel,
        input  ready
    );

    modport sink
    (
        input  valid, first_byte, second_byte, third_byte, fourth_byte,
               pixel_slot, last_pixel,
        output ready
    );
endinterface

### design/yuvrgb_cfg_if.sv
// ----------------------------------------------------------------------------
// yuvrgb_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface yuvrgb_cfg_if
    import yuvrgb_pkg::*;
();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    byte_t    data;

    modport source
    (
        output valid, index, data,
        input  ready
    );

    modport sink
    (
        input  valid, index, data,
        output ready
    );
endinterface

### design/yuv420_to_rgb_pixel_convert_unit.sv
// ----------------------------------------------------------------------------
// yuv420_to_rgb_pixel_convert_unit
// BT.601 fixed-point YUV 4:2:0 to RGB conversion, one 2x2 group in, four pixels out.
// ----------------------------------------------------------------------------
// Usage:
//   yuv  - sink of groups: four luma samples and the shared U/V pair.
//   rgb  - source of pixels, one per word: three color bytes in RGB or BGR
//          order, a fourth byte (alpha_fill or zero), pixel_slot and
//          last_pixel on the bottom-right pixel.
//   cfg  - register writes: 0 blue_first, 1 four_channels, 2 alpha_fill.
//          Always ready; other indexes are dropped. Write only while idle.
// Timing:
//   A group is held in an input register; the pixel selected by a slot
//   counter is computed and lands in the output register, one pixel per
//   cycle while the output is not stalled.
//   The four pixels of a group share the single pixel datapath.
//   The next group is taken in the cycle its predecessor's last pixel moves
//   to the output register, so pixels stream without gaps.
// Reset: both registers empty, blue_first 0, four_channels 0, alpha_fill 255.
// Stall: a valid output word holds while rgb.ready is low and the datapath stops;
//   yuv.ready stays low until the held group's last pixel can move on.
// ----------------------------------------------------------------------------
module yuv420_to_rgb_pixel_convert_unit
    import yuvrgb_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    yuvrgb_group_if.sink   yuv,
    yuvrgb_pixel_if.source rgb,
    yuvrgb_cfg_if.sink     cfg
);

    // control
    logic  grp_valid_reg;
    slot_t slot_reg;
    logic  out_valid_reg;
    logic  blue_first_reg;
    logic  four_channels_reg;
    byte_t alpha_fill_reg;

    // payload
    byte_t luma_reg [4];
    byte_t chroma_u_reg;
    byte_t chroma_v_reg;
    byte_t first_reg;
    byte_t second_reg;
    byte_t third_reg;
    byte_t fourth_reg;
    slot_t slot_out_reg;
    logic  last_out_reg;

    logic  advance;
    logic  last_slot;
    logic  grp_accept;

    byte_t              luma_sel;
    logic [7:0]         luma_lift;
    logic [16:0]        y_prod;
    logic [8:0]         y_scaled;
    logic signed [7:0]  u_off;
    logic signed [7:0]  v_off;
    logic signed [15:0] rv_prod;
    logic signed [15:0] gu_prod;
    logic signed [15:0] gv_prod;
    logic signed [15:0] bu_prod;
    logic signed [9:0]  r_off;
    logic signed [9:0]  g_off;
    logic signed [9:0]  b_off;
    logic signed [10:0] r_sum;
    logic signed [10:0] g_sum;
    logic signed [10:0] b_sum;
    byte_t              red;
    byte_t              green;
    byte_t              blue;

    function automatic byte_t sat8(input logic signed [10:0] x);
        byte_t res;
        if (x < 0)
        begin
            res = '0;
        end
        else if (x > 11'sd255)
        begin
            res = '1;
        end
        else
        begin
            res = x[7:0];
        end
        return res;
    endfunction

    assign last_slot  = (slot_reg == SLOT_BOTTOM_RIGHT);
    assign advance    = grp_valid_reg && (!out_valid_reg || rgb.ready);
    assign yuv.ready  = !grp_valid_reg || (advance && last_slot);
    assign grp_accept = yuv.valid && yuv.ready;
    assign cfg.ready  = 1'b1;

    // ---- pixel datapath ----
    always_comb
    begin
        unique case (slot_reg)
            SLOT_TOP_LEFT:     luma_sel = luma_reg[0];
            SLOT_TOP_RIGHT:    luma_sel = luma_reg[1];
            SLOT_BOTTOM_LEFT:  luma_sel = luma_reg[2];
            SLOT_BOTTOM_RIGHT: luma_sel = luma_reg[3];
            default:           luma_sel = luma_reg[0];
        endcase
    end

    assign luma_lift = (luma_sel > LUMA_BLACK) ? (luma_sel - LUMA_BLACK) : '0;
    assign y_prod    = 17'(luma_lift) * Y_GAIN;
    assign y_scaled  = y_prod[15:7];

    // flipping the top bit of an offset-128 byte gives its signed value
    assign u_off = $signed({~chroma_u_reg[7], chroma_u_reg[6:0]});
    assign v_off = $signed({~chroma_v_reg[7], chroma_v_reg[6:0]});

    assign rv_prod = 16'(v_off) * RV_GAIN;
    assign gu_prod = 16'(u_off) * GU_GAIN;
    assign gv_prod = 16'(v_off) * GV_GAIN;
    assign bu_prod = 16'(u_off) * BU_GAIN;

    // arithmetic shift = floor division by 64
    assign r_off = 10'(rv_prod >>> 6);
    assign g_off = 10'(gu_prod >>> 6) + 10'(gv_prod >>> 6);
    assign b_off = 10'(bu_prod >>> 6);

    assign r_sum = $signed({2'b00, y_scaled}) + 11'(r_off);
    assign g_sum = $signed({2'b00, y_scaled}) - 11'(g_off);
    assign b_sum = $signed({2'b00, y_scaled}) + 11'(b_off);

    assign red   = sat8(r_sum);
    assign green = sat8(g_sum);
    assign blue  = sat8(b_sum);

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_valid_reg <= 1'b0;
            slot_reg      <= SLOT_TOP_LEFT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (grp_accept)
            begin
                grp_valid_reg <= 1'b1;
                slot_reg      <= SLOT_TOP_LEFT;
            end
            else if (advance)
            begin
                slot_reg <= slot_reg + 1'b1;
                if (last_slot)
                begin
                    grp_valid_reg <= 1'b0;
                end
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rgb.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blue_first_reg    <= 1'b0;
            four_channels_reg <= 1'b0;
            alpha_fill_reg    <= ALPHA_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_BLUE_FIRST:    blue_first_reg    <= cfg.data[0];
                CFG_FOUR_CHANNELS: four_channels_reg <= cfg.data[0];
                CFG_ALPHA_FILL:    alpha_fill_reg    <= cfg.data;
                default:           ;
            endcase
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (grp_accept)
        begin
            luma_reg[0]  <= yuv.luma_top_left;
            luma_reg[1]  <= yuv.luma_top_right;
            luma_reg[2]  <= yuv.luma_bottom_left;
            luma_reg[3]  <= yuv.luma_bottom_right;
            chroma_u_reg <= yuv.chroma_u;
            chroma_v_reg <= yuv.chroma_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            first_reg    <= blue_first_reg ? blue : red;
            second_reg   <= green;
            third_reg    <= blue_first_reg ? red : blue;
            fourth_reg   <= four_channels_reg ? alpha_fill_reg : '0;
            slot_out_reg <= slot_reg;
            last_out_reg <= last_slot;
        end
    end

    assign rgb.valid       = out_valid_reg;
    assign rgb.first_byte  = first_reg;
    assign rgb.second_byte = second_reg;
    assign rgb.third_byte  = third_reg;
    assign rgb.fourth_byte = fourth_reg;
    assign rgb.pixel_slot  = slot_out_reg;
    assign rgb.last_pixel  = last_out_reg;

endmodule

### design/yuvrgb_checker.sv
// ----------------------------------------------------------------------------
// yuvrgb_checker
// Port-level checks of the YUV to RGB unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module yuvrgb_checker
    import yuvrgb_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  yuv_ready,
    input logic  rgb_valid,
    input logic  rgb_ready,
    input byte_t rgb_first_byte,
    input slot_t rgb_pixel_slot,
    input logic  rgb_last_pixel
);

    logic rgb_taken;
    logic rgb_mid_group;

    assign rgb_taken     = rgb_valid && rgb_ready;
    assign rgb_mid_group = (rgb_pixel_slot != SLOT_BOTTOM_RIGHT);

    `ASSERT_ALWAYS(a_last_flag, !rgb_valid || (rgb_last_pixel == !rgb_mid_group),
        "last_pixel does not match the bottom-right slot")

    // pixels of one group follow without gaps
    `ASSERT_PROP(a_slot_order, rgb_taken && rgb_mid_group |=>
        rgb_valid && (rgb_pixel_slot == slot_t'($past(rgb_pixel_slot) + 1'b1)),
        "pixel slot sequence broken")

    // an unfinished group blocks the input
    `ASSERT_ALWAYS(a_group_busy, !(rgb_valid && !rgb_ready && rgb_mid_group) || !yuv_ready,
        "new group accepted while a group is still in progress")

    `ASSERT_PROP(a_stall_hold, rgb_valid && !rgb_ready |=>
        rgb_valid && $stable(rgb_first_byte) && $stable(rgb_pixel_slot),
        "stalled pixel word changed")

endmodule

bind yuv420_to_rgb_pixel_convert_unit yuvrgb_checker u_yuvrgb_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .yuv_ready      (yuv.ready),
    .rgb_valid      (rgb.valid),
    .rgb_ready      (rgb.ready),
    .rgb_first_byte (rgb.first_byte),
    .rgb_pixel_slot (rgb.pixel_slot),
    .rgb_last_pixel (rgb.last_pixel)
);
